>>> design/sba_pkg.sv
package sba_pkg;

    localparam int MAP_BYTES_DEF  = 512;
    localparam int GROW_BYTES_DEF = 8;
    localparam int MAX_CAP        = 512;

    localparam logic [3:0] CMD_ALLOC    = 4'd0;
    localparam logic [3:0] CMD_FREE     = 4'd1;
    localparam logic [3:0] CMD_MARK     = 4'd2;
    localparam logic [3:0] CMD_TEST_ST  = 4'd3;
    localparam logic [3:0] CMD_TEST_NOW = 4'd4;
    localparam logic [3:0] CMD_FIND     = 4'd5;
    localparam logic [3:0] CMD_COMMIT   = 4'd6;
    localparam logic [3:0] CMD_CLEAR    = 4'd7;
    localparam logic [3:0] CMD_RECALC   = 4'd8;
    localparam logic [3:0] CMD_LOAD     = 4'd9;

    localparam logic [7:0] BYTE_FULL = 8'hff;
    localparam logic [7:0] BIT_ONE   = 8'h01;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [11:0] block_number;
        logic [8:0]  byte_index;
        logic [7:0]  byte_value;
    } in_item_t;

    typedef struct packed {
        logic [11:0] result_block;
        logic        flag;
        logic [9:0]  bytes_used;
        logic [11:0] last_used_block;
        logic        status;
    } out_item_t;

    function automatic logic [2:0] low_zero(input logic [7:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!v[k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

    function automatic logic [2:0] low_one(input logic [7:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (v[k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

    function automatic logic [2:0] high_one(input logic [7:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (v[k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

endpackage

>>> design/shadow_bitmap_block_allocator.sv
// Channel | Signals                         | Direction
// cmd     | cmd_valid, cmd_stall, cmd_item  | item in, stall out
// rsp     | rsp_valid, rsp_stall, rsp_item  | item out, stall in
//
// One item at a time: accept, read each map byte needed through the RAM read
// port, then give the result. Test reads one byte; free and mark read one
// byte when it lies in the map; alloc, find changed, commit, clear and recalc
// read one per byte scanned. Load and growth write the byte and zero each new
// byte. Unused codes and commands with nothing to read go to the result. No
// clearing pass after reset. A waiting result does not block the next item,
// which may run until its own result is ready.
module shadow_bitmap_block_allocator #(
    parameter int MAP_BYTES  = sba_pkg::MAP_BYTES_DEF,
    parameter int GROW_BYTES = sba_pkg::GROW_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sba_pkg::in_item_t  cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sba_pkg::out_item_t rsp_item
);

    localparam int CAP = (MAP_BYTES < sba_pkg::MAX_CAP) ? MAP_BYTES : sba_pkg::MAX_CAP;
    localparam int AW  = $clog2(CAP > 1 ? CAP : 2);

    logic               busy, done, take;
    logic               re, we;
    logic [AW-1:0]      raddr, waddr;
    logic [15:0]        rdata, wdata;
    sba_pkg::out_item_t res;
    logic               rsp_valid_reg;
    sba_pkg::out_item_t rsp_item_reg;

    assign cmd_stall = busy;
    assign take      = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    sba_ram #(.WIDTH(16), .DEPTH(CAP)) u_map (
        .clk(clk), .re(re), .raddr(raddr), .rdata(rdata),
        .we(we), .waddr(waddr), .wdata(wdata)
    );

    sba_core #(.MAP_BYTES(MAP_BYTES), .GROW_BYTES(GROW_BYTES), .AW(AW)) u_core (
        .clk(clk), .rst_n(rst_n), .start(cmd_valid && !busy), .item(cmd_item),
        .busy(busy), .done(done), .res(res), .take(take),
        .re(re), .raddr(raddr), .rdata(rdata),
        .we(we), .waddr(waddr), .wdata(wdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            rsp_valid_reg <= done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            rsp_item_reg <= res;
        end
    end

endmodule

>>> design/sba_ram.sv
module sba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                             clk,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/sba_core.sv
module sba_core #(
    parameter int MAP_BYTES  = sba_pkg::MAP_BYTES_DEF,
    parameter int GROW_BYTES = sba_pkg::GROW_BYTES_DEF,
    parameter int AW         = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sba_pkg::in_item_t  item,
    output logic               busy,
    output logic               done,
    output sba_pkg::out_item_t res,
    input  logic               take,
    output logic               re,
    output logic [AW-1:0]      raddr,
    input  logic [15:0]        rdata,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output logic [15:0]        wdata
);

    localparam int CAP = (MAP_BYTES < sba_pkg::MAX_CAP) ? MAP_BYTES : sba_pkg::MAX_CAP;
    localparam logic [10:0] CAP_W  = 11'(CAP);
    localparam logic [10:0] GROW_W = 11'(GROW_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EV, S_GROW, S_WR, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [11:0] blk_reg, blk_next;
    logic [7:0]  bval_reg, bval_next;
    logic [9:0]  ptr_reg, ptr_next;
    logic [9:0]  tgt_reg, tgt_next;
    logic [9:0]  gptr_reg, gptr_next;
    logic [9:0]  in_use_reg, in_use_next;
    logic [9:0]  low_reg, low_next;
    logic [11:0] last_reg, last_next;
    logic [11:0] rblk_reg, rblk_next;
    logic        flag_reg, flag_next;
    logic        stat_reg, stat_next;

    logic [9:0]  byi;
    logic [7:0]  bitm;
    logic        in_rng;
    logic [7:0]  cur_b, st_b, x_b, nc_b, c_b, lo_m, hi_m;
    logic [2:0]  p;
    logic [11:0] n_blk;
    logic [10:0] chunk_sum, chunk_end, gnext;
    logic [9:0]  ibyi;

    assign byi       = {1'b0, blk_reg[11:3]};
    assign bitm      = sba_pkg::BIT_ONE << blk_reg[2:0];
    assign ibyi      = {1'b0, item.block_number[11:3]};
    assign in_rng    = ptr_reg < in_use_reg;
    assign cur_b     = in_rng ? rdata[7:0] : 8'h00;
    assign st_b      = in_rng ? rdata[15:8] : 8'h00;
    assign x_b       = cur_b | st_b;
    assign p         = sba_pkg::low_zero(x_b);
    assign n_blk     = {ptr_reg[8:0], p};
    assign nc_b      = cur_b | bitm;
    assign lo_m      = (ptr_reg == byi) ? (sba_pkg::BYTE_FULL << blk_reg[2:0])
                                        : sba_pkg::BYTE_FULL;
    assign hi_m      = (ptr_reg == {1'b0, last_reg[11:3]})
                       ? (sba_pkg::BYTE_FULL >> (3'd7 - last_reg[2:0]))
                       : sba_pkg::BYTE_FULL;
    assign c_b       = cur_b & ~st_b & lo_m & hi_m;
    assign chunk_sum = {1'b0, in_use_reg} + GROW_W;
    assign chunk_end = (chunk_sum > CAP_W) ? CAP_W : chunk_sum;
    assign gnext     = {1'b0, gptr_reg} + 11'd1;

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT;
    assign res  = '{result_block: rblk_reg, flag: flag_reg, bytes_used: in_use_reg,
                    last_used_block: last_reg, status: stat_reg};

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        blk_next    = blk_reg;
        bval_next   = bval_reg;
        ptr_next    = ptr_reg;
        tgt_next    = tgt_reg;
        gptr_next   = gptr_reg;
        in_use_next = in_use_reg;
        low_next    = low_reg;
        last_next   = last_reg;
        rblk_next   = rblk_reg;
        flag_next   = flag_reg;
        stat_next   = stat_reg;
        re          = 1'b0;
        raddr       = ptr_reg[AW-1:0];
        we          = 1'b0;
        waddr       = ptr_reg[AW-1:0];
        wdata       = {st_b, cur_b};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = item.cmd;
                    blk_next  = item.block_number;
                    bval_next = item.byte_value;
                    rblk_next = 12'd0;
                    flag_next = 1'b0;
                    stat_next = 1'b0;
                    gptr_next = in_use_reg;
                    ptr_next  = ibyi;
                    state_next = S_RD;
                    case (item.cmd)
                        sba_pkg::CMD_ALLOC:
                        begin
                            ptr_next = low_reg;
                        end
                        sba_pkg::CMD_FREE:
                        begin
                            if (ibyi >= in_use_reg)
                            begin
                                if (low_reg > ibyi)
                                begin
                                    low_next = ibyi;
                                end
                                state_next = S_OUT;
                            end
                        end
                        sba_pkg::CMD_MARK:
                        begin
                            tgt_next = ibyi;
                            if ({1'b0, ibyi} >= CAP_W)
                            begin
                                stat_next  = 1'b1;
                                state_next = S_OUT;
                            end
                            else if (ibyi >= in_use_reg)
                            begin
                                state_next = S_GROW;
                            end
                        end
                        sba_pkg::CMD_TEST_ST, sba_pkg::CMD_TEST_NOW:
                        begin
                            state_next = S_RD;
                        end
                        sba_pkg::CMD_FIND:
                        begin
                            if (item.block_number > last_reg)
                            begin
                                state_next = S_OUT;
                            end
                        end
                        sba_pkg::CMD_COMMIT, sba_pkg::CMD_CLEAR:
                        begin
                            ptr_next = 10'd0;
                            if (item.cmd == sba_pkg::CMD_COMMIT)
                            begin
                                low_next = 10'd0;
                            end
                            if (in_use_reg == 10'd0)
                            begin
                                state_next = S_OUT;
                            end
                        end
                        sba_pkg::CMD_RECALC:
                        begin
                            ptr_next = in_use_reg - 10'd1;
                            if (in_use_reg == 10'd0)
                            begin
                                last_next  = 12'd0;
                                state_next = S_OUT;
                            end
                        end
                        sba_pkg::CMD_LOAD:
                        begin
                            tgt_next = {1'b0, item.byte_index};
                            if ({2'b00, item.byte_index} >= CAP_W)
                            begin
                                stat_next  = 1'b1;
                                state_next = S_OUT;
                            end
                            else if ({1'b0, item.byte_index} >= in_use_reg)
                            begin
                                state_next = S_GROW;
                            end
                            else
                            begin
                                state_next = S_WR;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (cmd_reg == sba_pkg::CMD_ALLOC && {1'b0, ptr_reg} >= CAP_W)
                begin
                    stat_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    re         = 1'b1;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    sba_pkg::CMD_ALLOC:
                    begin
                        if (x_b == sba_pkg::BYTE_FULL)
                        begin
                            ptr_next   = ptr_reg + 10'd1;
                            state_next = S_RD;
                        end
                        else
                        begin
                            rblk_next = n_blk;
                            low_next  = ptr_reg;
                            if (n_blk > last_reg)
                            begin
                                last_next = n_blk;
                            end
                            if (!in_rng)
                            begin
                                tgt_next   = ptr_reg;
                                gptr_next  = in_use_reg;
                                state_next = S_GROW;
                            end
                            else
                            begin
                                we    = 1'b1;
                                wdata = {st_b, cur_b | (sba_pkg::BIT_ONE << p)};
                            end
                        end
                    end
                    sba_pkg::CMD_FREE:
                    begin
                        we    = 1'b1;
                        wdata = {st_b, cur_b & ~bitm};
                        if (low_reg > byi && (st_b & bitm) == 8'h00)
                        begin
                            low_next = byi;
                        end
                    end
                    sba_pkg::CMD_MARK:
                    begin
                        we    = 1'b1;
                        wdata = {st_b, nc_b};
                        if (low_reg == byi && nc_b == sba_pkg::BYTE_FULL)
                        begin
                            low_next = low_reg + 10'd1;
                        end
                    end
                    sba_pkg::CMD_TEST_ST:
                    begin
                        flag_next = (st_b & bitm) == 8'h00;
                    end
                    sba_pkg::CMD_TEST_NOW:
                    begin
                        flag_next = (cur_b & bitm) == 8'h00;
                    end
                    sba_pkg::CMD_FIND:
                    begin
                        if (c_b != 8'h00)
                        begin
                            rblk_next = {ptr_reg[8:0], sba_pkg::low_one(c_b)};
                            flag_next = 1'b1;
                        end
                        else if (ptr_reg != {1'b0, last_reg[11:3]})
                        begin
                            ptr_next   = ptr_reg + 10'd1;
                            state_next = S_RD;
                        end
                    end
                    sba_pkg::CMD_COMMIT, sba_pkg::CMD_CLEAR:
                    begin
                        we    = 1'b1;
                        wdata = (cmd_reg == sba_pkg::CMD_COMMIT) ? {cur_b, cur_b}
                                                                 : {st_b, 8'h00};
                        if (ptr_reg + 10'd1 != in_use_reg)
                        begin
                            ptr_next   = ptr_reg + 10'd1;
                            state_next = S_RD;
                        end
                    end
                    sba_pkg::CMD_RECALC:
                    begin
                        if (cur_b == 8'h00)
                        begin
                            in_use_next = ptr_reg;
                            if (ptr_reg == 10'd0)
                            begin
                                last_next = 12'd0;
                            end
                            else
                            begin
                                ptr_next   = ptr_reg - 10'd1;
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            last_next = {ptr_reg[8:0], sba_pkg::high_one(cur_b)};
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_GROW:
            begin
                we        = 1'b1;
                waddr     = gptr_reg[AW-1:0];
                wdata     = 16'h0000;
                gptr_next = gnext[9:0];
                if (gnext == chunk_end)
                begin
                    in_use_next = chunk_end[9:0];
                    if (chunk_end > {1'b0, tgt_reg})
                    begin
                        state_next = S_WR;
                    end
                end
            end
            S_WR:
            begin
                we         = 1'b1;
                waddr      = tgt_reg[AW-1:0];
                state_next = S_OUT;
                case (cmd_reg)
                    sba_pkg::CMD_ALLOC: wdata = {8'h00, sba_pkg::BIT_ONE};
                    sba_pkg::CMD_MARK:  wdata = {8'h00, bitm};
                    default:            wdata = {bval_reg, bval_reg};
                endcase
            end
            S_OUT:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= sba_pkg::CMD_ALLOC;
            blk_reg    <= 12'd0;
            bval_reg   <= 8'd0;
            ptr_reg    <= 10'd0;
            tgt_reg    <= 10'd0;
            gptr_reg   <= 10'd0;
            in_use_reg <= 10'd0;
            low_reg    <= 10'd0;
            last_reg   <= 12'd0;
            rblk_reg   <= 12'd0;
            flag_reg   <= 1'b0;
            stat_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            blk_reg    <= blk_next;
            bval_reg   <= bval_next;
            ptr_reg    <= ptr_next;
            tgt_reg    <= tgt_next;
            gptr_reg   <= gptr_next;
            in_use_reg <= in_use_next;
            low_reg    <= low_next;
            last_reg   <= last_next;
            rblk_reg   <= rblk_next;
            flag_reg   <= flag_next;
            stat_reg   <= stat_next;
        end
    end

endmodule

>>> design/sba_checker.sv
module sba_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input sba_pkg::in_item_t  cmd_item,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input sba_pkg::out_item_t rsp_item
);

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_item))
        else $error("input item changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second item taken while one is in work");

    a_full_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status |-> rsp_item.result_block == 12'd0 && !rsp_item.flag)
        else $error("capacity status with a block result");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.bytes_used <= 10'd512)
        else $error("bytes used beyond capacity");

endmodule

bind shadow_bitmap_block_allocator sba_checker u_sba_checker (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
);

>>> tb/shadow_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps

module shadow_bitmap_block_allocator_tb;

    localparam int CAP_BYTES = 512;
    localparam int GROW_STEP = 8;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int LONG_HOLD = 400;
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    sba_pkg::in_item_t  cmd_item = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    sba_pkg::out_item_t rsp_item;

    shadow_bitmap_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the allocator state
    logic [7:0] live_map [CAP_BYTES];
    logic [7:0] txn_map [CAP_BYTES];
    int         hint_byte;
    int         used_bytes;
    int         top_block;

    sba_pkg::out_item_t pending_rsp [$];
    int         fail_count = 0;
    int         burst_left = 0;
    bit         no_gaps = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         stall_mode = 0;
    int         idle_cycles = 0;

    function automatic logic [7:0] live_at(int i);
        return (i < used_bytes) ? live_map[i] : 8'h00;
    endfunction

    function automatic logic [7:0] txn_at(int i);
        return (i < used_bytes) ? txn_map[i] : 8'h00;
    endfunction

    function automatic void grow_map(int i);
        int nsz;
        while (used_bytes <= i)
        begin
            nsz = used_bytes + GROW_STEP;
            if (nsz > CAP_BYTES)
            begin
                nsz = CAP_BYTES;
            end
            for (int k = used_bytes; k < nsz; k++)
            begin
                live_map[k] = 8'h00;
                txn_map[k] = 8'h00;
            end
            used_bytes = nsz;
        end
    endfunction

    function automatic sba_pkg::out_item_t apply_cmd(sba_pkg::in_item_t it);
        sba_pkg::out_item_t r;
        int         byi;
        int         i;
        int         n;
        int         sz;
        logic [7:0] msk;
        logic [7:0] x;
        logic [7:0] t_b;
        logic [7:0] l_b;
        r = '0;
        byi = int'(it.block_number >> 3);
        msk = sba_pkg::BIT_ONE << it.block_number[2:0];
        case (it.cmd)
            sba_pkg::CMD_ALLOC:
            begin
                i = hint_byte;
                x = sba_pkg::BYTE_FULL;
                while (i < CAP_BYTES)
                begin
                    x = live_at(i) | txn_at(i);
                    if (x != sba_pkg::BYTE_FULL)
                    begin
                        break;
                    end
                    i++;
                end
                if (i >= CAP_BYTES)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    grow_map(i);
                    n = i * 8;
                    while (x[n % 8])
                    begin
                        n++;
                    end
                    live_map[i][n % 8] = 1'b1;
                    hint_byte = i;
                    if (n > top_block)
                    begin
                        top_block = n;
                    end
                    r.result_block = 12'(n);
                end
            end
            sba_pkg::CMD_FREE:
            begin
                if (byi < used_bytes)
                begin
                    live_map[byi] = live_map[byi] & ~msk;
                end
                if (hint_byte > byi && (txn_at(byi) & msk) == 8'h00)
                begin
                    hint_byte = byi;
                end
            end
            sba_pkg::CMD_MARK:
            begin
                grow_map(byi);
                live_map[byi] = live_map[byi] | msk;
                if (hint_byte == byi && live_map[byi] == sba_pkg::BYTE_FULL)
                begin
                    hint_byte++;
                end
            end
            sba_pkg::CMD_TEST_ST:
            begin
                r.flag = (txn_at(byi) & msk) == 8'h00;
            end
            sba_pkg::CMD_TEST_NOW:
            begin
                r.flag = (live_at(byi) & msk) == 8'h00;
            end
            sba_pkg::CMD_FIND:
            begin
                for (n = int'(it.block_number); n <= top_block && n < 4096; n++)
                begin
                    t_b = txn_at(n / 8);
                    l_b = live_at(n / 8);
                    if (!t_b[n % 8] && l_b[n % 8])
                    begin
                        r.result_block = 12'(n);
                        r.flag = 1'b1;
                        break;
                    end
                end
            end
            sba_pkg::CMD_COMMIT:
            begin
                for (int k = 0; k < used_bytes; k++)
                begin
                    txn_map[k] = live_map[k];
                end
                hint_byte = 0;
            end
            sba_pkg::CMD_CLEAR:
            begin
                for (int k = 0; k < used_bytes; k++)
                begin
                    live_map[k] = 8'h00;
                end
            end
            sba_pkg::CMD_RECALC:
            begin
                sz = used_bytes;
                while (sz > 0 && live_map[sz - 1] == 8'h00)
                begin
                    sz--;
                end
                used_bytes = sz;
                top_block = 0;
                if (sz > 0)
                begin
                    n = sz * 8 - 1;
                    while (!live_map[sz - 1][n % 8])
                    begin
                        n--;
                    end
                    top_block = n;
                end
            end
            sba_pkg::CMD_LOAD:
            begin
                grow_map(int'(it.byte_index));
                live_map[it.byte_index] = it.byte_value;
                txn_map[it.byte_index] = it.byte_value;
            end
            default:
            begin
            end
        endcase
        r.bytes_used = 10'(used_bytes);
        r.last_used_block = 12'(top_block);
        return r;
    endfunction

    task automatic send_item(sba_pkg::in_item_t it);
        if (burst_left == 0)
        begin
            if (!no_gaps)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        cmd_valid <= 1'b1;
        cmd_item <= it;
        burst_left--;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        pending_rsp.push_back(apply_cmd(it));
    endtask

    task automatic send_cmd(logic [3:0] c, int blk, int bidx = 0, int bval = 0);
        sba_pkg::in_item_t it;
        it.cmd = c;
        it.block_number = 12'(blk);
        it.byte_index = 9'(bidx);
        it.byte_value = 8'(bval);
        send_item(it);
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        sba_pkg::out_item_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected item %p", $time, rsp_item);
                fail_count++;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp_item.result_block !== exp_r.result_block)
                begin
                    $display("%0t: result_block exp %0d got %0d", $time,
                             exp_r.result_block, rsp_item.result_block);
                    fail_count++;
                end
                if (rsp_item.flag !== exp_r.flag)
                begin
                    $display("%0t: flag exp %0b got %0b", $time, exp_r.flag, rsp_item.flag);
                    fail_count++;
                end
                if (rsp_item.bytes_used !== exp_r.bytes_used)
                begin
                    $display("%0t: bytes_used exp %0d got %0d", $time,
                             exp_r.bytes_used, rsp_item.bytes_used);
                    fail_count++;
                end
                if (rsp_item.last_used_block !== exp_r.last_used_block)
                begin
                    $display("%0t: last_used_block exp %0d got %0d", $time,
                             exp_r.last_used_block, rsp_item.last_used_block);
                    fail_count++;
                end
                if (rsp_item.status !== exp_r.status)
                begin
                    $display("%0t: status exp %0b got %0b", $time,
                             exp_r.status, rsp_item.status);
                    fail_count++;
                end
            end
        end
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if ($urandom_range(0, 63) == 0)
        begin
            stall_mode = $urandom_range(0, 2);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (stall_mode == 0)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 3) < stall_mode);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles = 0;
        end
        else if (rst_n)
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_TEST_NOW, 0);
        send_cmd(sba_pkg::CMD_TEST_ST, 0);
        send_cmd(sba_pkg::CMD_FIND, 0);
        send_cmd(sba_pkg::CMD_COMMIT, 0);
        send_cmd(sba_pkg::CMD_FREE, 0);
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_FREE, 4095);
        send_cmd(sba_pkg::CMD_TEST_NOW, 4095);
        send_cmd(sba_pkg::CMD_MARK, 4095);
        send_cmd(sba_pkg::CMD_FIND, 4095);
        send_cmd(sba_pkg::CMD_LOAD, 0, 511, 255);
        send_cmd(sba_pkg::CMD_LOAD, 0, 3, 8'h5a);
        send_cmd(sba_pkg::CMD_TEST_ST, 25);
        send_cmd(sba_pkg::CMD_FIND, 0);
        send_cmd(CMD_UNUSED_LO, 4095, 511, 255);
        send_cmd(CMD_UNUSED_HI, 0);
        send_cmd(sba_pkg::CMD_CLEAR, 0);
        send_cmd(sba_pkg::CMD_RECALC, 0);
        send_cmd(sba_pkg::CMD_COMMIT, 0);
        send_cmd(sba_pkg::CMD_FREE, 9);
        send_cmd(sba_pkg::CMD_RECALC, 0);
        send_cmd(sba_pkg::CMD_MARK, 7);
        wait_drain();
    endtask

    task automatic test_full_map();
        for (int i = 0; i < CAP_BYTES; i++)
        begin
            send_cmd(sba_pkg::CMD_LOAD, 0, i, 255);
        end
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_FREE, 100);
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_COMMIT, 0);
        send_cmd(sba_pkg::CMD_ALLOC, 0);
        send_cmd(sba_pkg::CMD_CLEAR, 0);
        send_cmd(sba_pkg::CMD_RECALC, 0);
        send_cmd(sba_pkg::CMD_COMMIT, 0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        no_gaps = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            send_cmd(k % 2 ? sba_pkg::CMD_TEST_NOW : sba_pkg::CMD_MARK,
                     $urandom_range(0, 63));
        end
        no_gaps = 1'b0;
        wait_drain();
    endtask

    task automatic test_random(int count);
        int w;
        int blk;
        for (int k = 0; k < count; k++)
        begin
            w = $urandom_range(0, 99);
            blk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
            if (w < 25)
            begin
                send_cmd(sba_pkg::CMD_ALLOC, blk);
            end
            else if (w < 37)
            begin
                send_cmd(sba_pkg::CMD_FREE, blk);
            end
            else if (w < 47)
            begin
                send_cmd(sba_pkg::CMD_MARK, blk);
            end
            else if (w < 55)
            begin
                send_cmd(sba_pkg::CMD_TEST_ST, blk);
            end
            else if (w < 63)
            begin
                send_cmd(sba_pkg::CMD_TEST_NOW, blk);
            end
            else if (w < 73)
            begin
                send_cmd(sba_pkg::CMD_FIND, blk);
            end
            else if (w < 79)
            begin
                send_cmd(sba_pkg::CMD_COMMIT, blk);
            end
            else if (w < 83)
            begin
                send_cmd(sba_pkg::CMD_CLEAR, blk);
            end
            else if (w < 89)
            begin
                send_cmd(sba_pkg::CMD_RECALC, blk);
            end
            else if (w < 97)
            begin
                send_cmd(sba_pkg::CMD_LOAD, blk,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 31),
                         $urandom_range(0, 255));
            end
            else
            begin
                send_cmd(4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), blk,
                         $urandom_range(0, 511), $urandom_range(0, 255));
            end
        end
        wait_drain();
    endtask

    initial
    begin
        for (int i = 0; i < CAP_BYTES; i++)
        begin
            live_map[i] = 8'h00;
            txn_map[i] = 8'h00;
        end
        hint_byte = 0;
        used_bytes = 0;
        top_block = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(380);
        test_full_map();
        test_random(380);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> shadow_bitmap_block_allocator.f
design/sba_pkg.sv
design/sba_ram.sv
design/sba_core.sv
design/shadow_bitmap_block_allocator.sv
design/sba_checker.sv
tb/shadow_bitmap_block_allocator_tb.sv
